// ----- hdl/alds_pkg.sv -----
// Shared types, constants and word conversions for the array list block.
package alds_pkg;

  localparam int DEPTH     = 32;
  localparam int WORD_BITS = 32;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 5;
  localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int EXT_W  = (WORD_BITS > 32) ? WORD_BITS : 32;

  localparam logic [2:0] CMD_LIST    = 3'd0;
  localparam logic [2:0] CMD_APPEND  = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_PREPEND = 3'd3;
  localparam logic [2:0] CMD_SORT    = 3'd4;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BAD_POS = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DELETE,
    OP_PREPEND,
    OP_ROTATE,
    OP_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    word_t             value;
    logic [IDX_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    word_t             head;
    logic              phase;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic [4:0]         index;
    logic [5:0]         count;
    status_t            status;
    logic               last;
  } result_t;

  function automatic word_t to_word(input logic signed [31:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[WORD_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] from_word(input word_t w);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'($signed(w));
    return e[31:0];
  endfunction

endpackage

// ----- hdl/alds_in_if.sv -----
// Command request channel of the array list block.
interface alds_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] value;
  logic [4:0]         position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

// ----- hdl/alds_out_if.sv -----
// Result request channel of the array list block.
interface alds_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;
  logic [4:0]         index;
  logic [5:0]         count;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, element, index, count, status, last, input ready);
  modport sink   (input valid, element, index, count, status, last, output ready);
endinterface

// ----- hdl/alds_cell.sv -----
// One list cell: holds one entry and trades it with its neighbours.
module alds_cell (
  input  logic                    clk,
  input  logic [alds_pkg::IDX_W-1:0] idx,
  input  alds_pkg::cell_ctrl_t    ctrl,
  input  alds_pkg::word_t         left_word,
  input  alds_pkg::word_t         right_word,
  output alds_pkg::word_t         word
);

  alds_pkg::word_t             word_r;
  alds_pkg::word_t             word_nxt;
  logic [alds_pkg::CNT_W-1:0]  idx_c;
  logic [alds_pkg::CNT_W-1:0]  idx_p1;
  logic                        lower;

  assign idx_c  = alds_pkg::CNT_W'(idx);
  assign idx_p1 = idx_c + alds_pkg::CNT_W'(1);
  assign lower  = (idx[0] == ctrl.phase);
  assign word   = word_r;

  always_comb begin
    word_nxt = word_r;
    unique case (ctrl.op)
      alds_pkg::OP_HOLD: word_nxt = word_r;
      alds_pkg::OP_LOAD: begin
        if (idx_c == ctrl.count) word_nxt = ctrl.value;
      end
      alds_pkg::OP_DELETE: begin
        if (idx >= ctrl.pos) word_nxt = right_word;
      end
      alds_pkg::OP_PREPEND: word_nxt = left_word;
      alds_pkg::OP_ROTATE: begin
        if (idx_p1 < ctrl.count) word_nxt = right_word;
        else if (idx_p1 == ctrl.count) word_nxt = ctrl.head;
      end
      alds_pkg::OP_SORT: begin
        if (lower) begin
          if (idx_p1 < ctrl.count && $signed(word_r) < $signed(right_word))
            word_nxt = right_word;
        end else begin
          if (idx != '0 && idx_c < ctrl.count && $signed(left_word) < $signed(word_r))
            word_nxt = left_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

// ----- hdl/array_list_with_descending_sort.sv -----
// Top level: ordered list of signed words in a chain of cells, with descending sort.
//
// Commands arrive on in_chan (valid/ready); a request is taken when both are high.
// cmd 0 lists the entries, 1 appends value, 2 deletes at position, 3 prepends value,
// 4 sorts into descending order; other codes do nothing and report ok.
// Results leave on out_chan through one output register.
// Append, delete, prepend and unused codes: one status result, valid in the cycle after
// the request is taken; the next request is taken as soon as the output register frees.
// List: one result per entry, the first via the state register and then the output
// register, then one per cycle while the receiver takes them, the last one marked; an
// empty list gives a single empty status. The cells rotate one place per result, so
// listing leaves the order unchanged.
// Sort: odd-even transposition over the cells, DEPTH exchange phases, then one status
// result.
// Only one request is in progress at a time; in_chan.ready is low meanwhile.
// A stalled receiver holds the result register and the block waits.
// Reset empties the list and drops any pending result; stored words are not cleared.
module array_list_with_descending_sort (
  input  logic         clk,
  input  logic         rst_n,
  alds_in_if.sink      in_chan,
  alds_out_if.source   out_chan
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LIST   = 4'b0010,
    ST_SORT   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [alds_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [alds_pkg::IDX_W-1:0]   k_r, k_nxt;
  logic [alds_pkg::CNT_W-1:0]   ph_r, ph_nxt;
  logic                         out_valid_r, out_valid_nxt;
  alds_pkg::result_t            res_r, res_nxt;
  alds_pkg::cell_ctrl_t         ctrl;
  logic                         acc, slot_free, load_out, is_last;
  logic [alds_pkg::WIDE_W-1:0]  pos_ext;

  alds_pkg::word_t words   [alds_pkg::DEPTH];
  alds_pkg::word_t left_w  [alds_pkg::DEPTH];
  alds_pkg::word_t right_w [alds_pkg::DEPTH];

  assign slot_free     = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && slot_free;
  assign acc           = in_chan.valid && in_chan.ready;
  assign pos_ext       = alds_pkg::WIDE_W'(in_chan.position);
  assign is_last       = (alds_pkg::CNT_W'(k_r) + alds_pkg::CNT_W'(1)) == count_r;

  for (genvar g = 0; g < alds_pkg::DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = ctrl.value;
    end else begin : g_mid
      assign left_w[g] = words[g-1];
    end
    if (g == alds_pkg::DEPTH - 1) begin : g_end
      assign right_w[g] = words[g];
    end else begin : g_inner
      assign right_w[g] = words[g+1];
    end
    alds_cell u_cell (
      .clk        (clk),
      .idx        (alds_pkg::IDX_W'(g)),
      .ctrl       (ctrl),
      .left_word  (left_w[g]),
      .right_word (right_w[g]),
      .word       (words[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    ph_nxt         = ph_r;
    load_out       = 1'b0;
    ctrl.op        = alds_pkg::OP_HOLD;
    ctrl.value     = alds_pkg::to_word(in_chan.value);
    ctrl.pos       = pos_ext[alds_pkg::IDX_W-1:0];
    ctrl.count     = count_r;
    ctrl.head      = words[0];
    ctrl.phase     = ph_r[0];
    res_nxt        = '0;
    res_nxt.status = alds_pkg::STAT_OK;
    res_nxt.last   = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_chan.cmd)
            alds_pkg::CMD_LIST: begin
              if (count_r == '0) begin
                load_out       = 1'b1;
                res_nxt.status = alds_pkg::STAT_EMPTY;
              end else begin
                state_nxt = ST_LIST;
                k_nxt     = '0;
              end
            end
            alds_pkg::CMD_APPEND, alds_pkg::CMD_PREPEND: begin
              load_out = 1'b1;
              if (count_r == alds_pkg::CNT_W'(alds_pkg::DEPTH)) begin
                res_nxt.status = alds_pkg::STAT_FULL;
              end else begin
                ctrl.op   = (in_chan.cmd == alds_pkg::CMD_APPEND) ? alds_pkg::OP_LOAD
                                                                  : alds_pkg::OP_PREPEND;
                count_nxt = count_r + alds_pkg::CNT_W'(1);
              end
            end
            alds_pkg::CMD_DELETE: begin
              load_out = 1'b1;
              if (pos_ext >= alds_pkg::WIDE_W'(count_r)) begin
                res_nxt.status = alds_pkg::STAT_BAD_POS;
              end else begin
                ctrl.op   = alds_pkg::OP_DELETE;
                count_nxt = count_r - alds_pkg::CNT_W'(1);
              end
            end
            alds_pkg::CMD_SORT: begin
              state_nxt = ST_SORT;
              ph_nxt    = '0;
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          ctrl.op         = alds_pkg::OP_ROTATE;
          load_out        = 1'b1;
          res_nxt.element = alds_pkg::from_word(words[0]);
          res_nxt.index   = 5'(k_r);
          res_nxt.last    = is_last;
          if (is_last) state_nxt = ST_IDLE;
          else k_nxt = k_r + alds_pkg::IDX_W'(1);
        end
      end
      ST_SORT: begin
        ctrl.op = alds_pkg::OP_SORT;
        ph_nxt  = ph_r + alds_pkg::CNT_W'(1);
        if (ph_r == alds_pkg::CNT_W'(alds_pkg::DEPTH - 1)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    res_nxt.count = 6'(count_nxt);
    out_valid_nxt = load_out || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      ph_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) res_r <= res_nxt;
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.element = res_r.element;
  assign out_chan.index   = res_r.index;
  assign out_chan.count   = res_r.count;
  assign out_chan.status  = res_r.status;
  assign out_chan.last    = res_r.last;

endmodule

// ----- hdl/alds_checker.sv -----
// Port-level checks for the array list block, bound to the top level.
module alds_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_element,
  input logic [4:0]         out_index,
  input logic [5:0]         out_count,
  input logic [1:0]         out_status,
  input logic               out_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element) && $stable(out_index)
      && $stable(out_count) && $stable(out_status) && $stable(out_last))
    else $error("result changed while stalled");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 2'(alds_pkg::STAT_OK)
      |-> out_last && out_element == 32'sd0 && out_index == 5'd0)
    else $error("error or empty status not a lone zero result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 7'(out_count) <= 7'(alds_pkg::DEPTH))
    else $error("count beyond list depth");

  a_list_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == 2'(alds_pkg::STAT_OK) && out_count >= 6'd2)
    else $error("unfinished listing with bad status or short list");

endmodule

bind array_list_with_descending_sort alds_checker u_alds_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_element (out_chan.element),
  .out_index   (out_chan.index),
  .out_count   (out_chan.count),
  .out_status  (out_chan.status),
  .out_last    (out_chan.last)
);

// ----- verif/array_list_with_descending_sort_tb.sv -----
// Self-checking testbench for the array list block with descending sort.
module array_list_with_descending_sort_tb;
  import alds_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 120;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [4:0]         position;
  } list_cmd_t;

  logic clk;
  logic rst_n;

  alds_in_if  in_chan ();
  alds_out_if out_chan ();

  array_list_with_descending_sort DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  list_cmd_t cmd_backlog[$];
  result_t   pending_results[$];

  word_t shadow_list [DEPTH];
  int    shadow_len;
  int    gen_len;

  int cycles;
  int mismatches;
  int n_requests;
  int n_results;
  int n_lists;
  int n_sorts;
  int n_full;
  int n_bad_pos;
  int peak_len;

  int gap_left;
  int burst_left;
  int stall_mode;
  int stall_left;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected results of one accepted command, applied to the shadow list.
  function automatic void apply_command(input logic [2:0] op, input logic signed [31:0] val,
                                        input logic [4:0] pos);
    result_t r;
    word_t   t;
    int      i;
    int      j;
    r = '{element: 32'sd0, index: 5'd0, count: 6'd0, status: STAT_OK, last: 1'b1};
    case (op)
      CMD_LIST: begin
        n_lists++;
        if (shadow_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            r.element = 32'($signed(shadow_list[i]));
            r.index   = 5'(i);
            r.count   = 6'(shadow_len);
            r.last    = (i == shadow_len - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      CMD_APPEND, CMD_PREPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          if (op == CMD_APPEND) begin
            shadow_list[shadow_len] = word_t'(val);
          end else begin
            for (i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[0] = word_t'(val);
          end
          shadow_len++;
          if (shadow_len > peak_len) peak_len = shadow_len;
        end
      end
      CMD_DELETE: begin
        if (int'(pos) >= shadow_len) begin
          r.status = STAT_BAD_POS;
          n_bad_pos++;
        end else begin
          for (i = int'(pos); i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      CMD_SORT: begin
        n_sorts++;
        for (i = 0; i < shadow_len; i++) begin
          for (j = i + 1; j < shadow_len; j++) begin
            if ($signed(shadow_list[i]) < $signed(shadow_list[j])) begin
              t = shadow_list[i];
              shadow_list[i] = shadow_list[j];
              shadow_list[j] = t;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = 6'(shadow_len);
    pending_results.push_back(r);
  endfunction

  // Queues a request and tracks the list length it will leave behind.
  function automatic void queue_cmd(input logic [2:0] op, input logic signed [31:0] val,
                                    input logic [4:0] pos);
    list_cmd_t c;
    c.cmd      = op;
    c.value    = val;
    c.position = pos;
    cmd_backlog.push_back(c);
    if ((op == CMD_APPEND || op == CMD_PREPEND) && gen_len < DEPTH) gen_len++;
    else if (op == CMD_DELETE && int'(pos) < gen_len) gen_len--;
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 6)) - 3);
      1: return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] rand_push();
    return ($urandom_range(0, 1) != 0) ? CMD_APPEND : CMD_PREPEND;
  endfunction

  function automatic logic [4:0] valid_pos();
    return (gen_len > 0) ? 5'($urandom_range(0, gen_len - 1)) : 5'($urandom);
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        apply_command(in_chan.cmd, in_chan.value, in_chan.position);
        n_requests++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          in_chan.valid    <= 1'b1;
          in_chan.cmd      <= cmd_backlog[0].cmd;
          in_chan.value    <= cmd_backlog[0].value;
          in_chan.position <= cmd_backlog[0].position;
          void'(cmd_backlog.pop_front());
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own stall pattern.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{element: out_chan.element, index: out_chan.index, count: out_chan.count,
                status: status_t'(out_chan.status), last: out_chan.last};
        n_results++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: unexpected result elem %0d idx %0d cnt %0d st %0d last %0b",
                     cycles, got.element, got.index, got.count, got.status, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("cycle %0d: expected elem %0d idx %0d cnt %0d st %0d last %0b",
                       cycles, want.element, want.index, want.count, want.status, want.last);
              $display("  got elem %0d idx %0d cnt %0d st %0d last %0b",
                       got.element, got.index, got.count, got.status, got.last);
            end
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = (stall_mode == 3) ? $urandom_range(2, 16) : $urandom_range(8, 40);
      end
      stall_left--;
      case (stall_mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= cycles[0];
        2: out_chan.ready <= ($urandom_range(0, 1) != 0);
        default: out_chan.ready <= (stall_left == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int n;
    int k;
    in_chan.valid    = 1'b0;
    in_chan.cmd      = CMD_LIST;
    in_chan.value    = 32'sd0;
    in_chan.position = 5'd0;
    out_chan.ready   = 1'b0;
    rst_n            = 1'b0;
    shadow_len = 0;
    gen_len    = 0;
    cycles     = 0;
    mismatches = 0;
    n_requests = 0;
    n_results  = 0;
    n_lists    = 0;
    n_sorts    = 0;
    n_full     = 0;
    n_bad_pos  = 0;
    peak_len   = 0;

    // directed: empty list, extremes, every command, unused codes
    queue_cmd(CMD_LIST, 32'sd0, 5'd0);
    queue_cmd(CMD_DELETE, 32'sd0, 5'd0);
    queue_cmd(CMD_SORT, 32'sd0, 5'd0);
    queue_cmd(CMD_APPEND, 32'sh7FFFFFFF, 5'd0);
    queue_cmd(CMD_SORT, 32'sd0, 5'd0);
    queue_cmd(CMD_PREPEND, 32'sh80000000, 5'd31);
    queue_cmd(CMD_APPEND, 32'sd0, 5'd0);
    queue_cmd(CMD_APPEND, -32'sd1, 5'd0);
    queue_cmd(CMD_PREPEND, 32'sd1, 5'd0);
    queue_cmd(CMD_LIST, 32'sd0, 5'd0);
    queue_cmd(CMD_DELETE, 32'sd0, 5'd31);
    queue_cmd(CMD_DELETE, 32'sd0, 5'd4);
    queue_cmd(CMD_DELETE, 32'sd0, 5'd0);
    queue_cmd(CMD_SORT, 32'sd0, 5'd0);
    queue_cmd(CMD_LIST, 32'sd0, 5'd0);
    queue_cmd(3'd5, 32'sh55555555, 5'd31);
    queue_cmd(3'd6, -32'sd1, 5'd21);
    queue_cmd(3'd7, 32'sh80000000, 5'd10);
    queue_cmd(CMD_DELETE, 32'sd0, 5'd3);
    queue_cmd(CMD_APPEND, 32'sh55555555, 5'd0);
    queue_cmd(CMD_PREPEND, 32'shAAAAAAAA, 5'd0);
    queue_cmd(CMD_SORT, 32'sd0, 5'd0);
    queue_cmd(CMD_LIST, 32'sd0, 5'd0);

    // random: fill to full first, then drains, refills and mixed traffic
    while (gen_len < DEPTH) queue_cmd(rand_push(), rand_word(), 5'($urandom));
    queue_cmd(CMD_APPEND, rand_word(), 5'($urandom));
    queue_cmd(CMD_PREPEND, rand_word(), 5'($urandom));
    queue_cmd(CMD_LIST, rand_word(), 5'($urandom));
    queue_cmd(CMD_SORT, rand_word(), 5'($urandom));
    queue_cmd(CMD_LIST, rand_word(), 5'($urandom));
    while (cmd_backlog.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(3, 12);
          for (k = 0; k < n; k++) queue_cmd(CMD_DELETE, rand_word(), valid_pos());
          queue_cmd(CMD_LIST, rand_word(), 5'($urandom));
        end
        1: begin
          n = $urandom_range(3, 10);
          for (k = 0; k < n; k++) queue_cmd(rand_push(), rand_word(), 5'($urandom));
          queue_cmd(CMD_SORT, rand_word(), 5'($urandom));
          queue_cmd(CMD_LIST, rand_word(), 5'($urandom));
        end
        default: begin
          n = $urandom_range(5, 15);
          for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
              0, 1, 2:          queue_cmd(CMD_LIST, rand_word(), 5'($urandom));
              3, 4, 5, 6, 7:    queue_cmd(CMD_APPEND, rand_word(), 5'($urandom));
              8, 9, 10, 11:     queue_cmd(CMD_PREPEND, rand_word(), 5'($urandom));
              12, 13, 14, 15:   queue_cmd(CMD_DELETE, rand_word(), valid_pos());
              16, 17:           queue_cmd(CMD_SORT, rand_word(), 5'($urandom));
              18:               queue_cmd(CMD_DELETE, rand_word(), 5'($urandom));
              default:          queue_cmd(3'($urandom_range(5, 7)), rand_word(),
                                          5'($urandom));
            endcase
          end
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_chan.valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (pending_results.size() != 0)
      $display("%0d expected results never arrived", pending_results.size());
    $display("%0d requests (%0d list, %0d sort) gave %0d results; peak length %0d,",
             n_requests, n_lists, n_sorts, n_results, peak_len);
    $display("%0d full and %0d bad-position errors, %0d mismatches, %0d cycles",
             n_full, n_bad_pos, mismatches, cycles);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- array_list_with_descending_sort.f -----
hdl/alds_pkg.sv
hdl/alds_in_if.sv
hdl/alds_out_if.sv
hdl/alds_cell.sv
hdl/array_list_with_descending_sort.sv
hdl/alds_checker.sv
verif/array_list_with_descending_sort_tb.sv
